>>> hdl/palette_texel_decoder_top_defines.svh
// Assertion macros for the palette texel decoder checker
`ifndef PALETTE_TEXEL_DECODER_TOP_DEFINES_SVH
`define PALETTE_TEXEL_DECODER_TOP_DEFINES_SVH

// same-cycle implication on clk, disabled while rst_n is low
`define PTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, disabled while rst_n is low
`define PTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ptd_pkg.sv
// Shared types, codes and tables for the palette texel decoder
package ptd_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int IDX_W             = 8;
    localparam int WORD_W            = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TEXEL = 1'b1;

    localparam logic [2:0] IMG_A1BGR5 = 3'd0;
    localparam logic [2:0] IMG_XBGR8  = 3'd1;
    localparam logic [2:0] IMG_ABGR8  = 3'd2;
    localparam logic [2:0] IMG_CLUT4  = 3'd3;
    localparam logic [2:0] IMG_CLUT8  = 3'd4;

    localparam logic [2:0] PAL_NONE   = 3'd0;
    localparam logic [2:0] PAL_A1BGR5 = 3'd1;
    localparam logic [2:0] PAL_XBGR8  = 3'd2;
    localparam logic [2:0] PAL_ABGR8  = 3'd3;

    localparam logic [1:0] COLOR_A1BGR5 = 2'd0;
    localparam logic [1:0] COLOR_XBGR8  = 2'd1;
    localparam logic [1:0] COLOR_ABGR8  = 2'd2;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_BAD_IMAGE   = 2'd1;
    localparam logic [1:0] STATUS_BAD_PALETTE = 2'd2;

    localparam logic CFG_IMAGE_FORMAT   = 1'b0;
    localparam logic CFG_PALETTE_FORMAT = 1'b1;

    // floor(v * 255 / 31)
    localparam logic [7:0] SCALE5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // red in the low byte when packed onto the bus
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        pixel_t     pixel;
        logic [1:0] status;
        logic       last;
    } dec_out_t;

    function automatic pixel_t unpack_color(input logic [WORD_W-1:0] w,
                                            input logic [1:0] kind);
        pixel_t p;
        p = '0;
        unique case (kind)
            COLOR_A1BGR5:
            begin
                p.red   = SCALE5_LUT[w[4:0]];
                p.green = SCALE5_LUT[w[9:5]];
                p.blue  = SCALE5_LUT[w[14:10]];
                p.alpha = w[15] ? 8'hFF : 8'h00;
            end
            COLOR_XBGR8:
            begin
                p.red   = w[7:0];
                p.green = w[15:8];
                p.blue  = w[23:16];
                p.alpha = 8'hFF;
            end
            default:
            begin
                p.red   = w[7:0];
                p.green = w[15:8];
                p.blue  = w[23:16];
                p.alpha = w[31:24];
            end
        endcase
        return p;
    endfunction

endpackage

>>> hdl/palette_texel_decoder_top.sv
// Top level of the palette texel decoder
// A texel is registered with its palette reads, then decoded into the single output register.
// Throughput: one item per cycle when the output does not stall; a CLUT4 texel gives two pixels,
// one at a time, and holds the input meanwhile. Palette writes give no transfer out.
// Reset clears the pipeline valids and sets image format A1BGR5, palette format ABGR8;
// palette contents are undefined until written.
module palette_texel_decoder_top #(
    parameter int PALETTE_DEPTH = ptd_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // entry_index[7:0], data_word[39:8]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data
);
    import ptd_pkg::*;

    logic [2:0]        image_format_reg;
    logic [2:0]        palette_format_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_second_reg;
    logic              s1_second_next;
    logic [WORD_W-1:0] s1_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    dec_out_t          out_reg;

    logic              in_xfer;
    logic              texel_xfer;
    logic              out_free;
    logic              s1_emit;
    logic              s1_done;
    logic [7:0]        b0;
    logic [7:0]        addr0;
    logic [7:0]        addr1;
    logic [WORD_W-1:0] entry0;
    logic [WORD_W-1:0] entry1;
    dec_out_t          dec;

    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || m_tready;
    assign s1_emit    = s1_valid_reg && out_free;
    assign s1_done    = s1_emit && dec.last;
    assign s_tready   = !s1_valid_reg || s1_done;
    assign in_xfer    = s_tvalid && s_tready;
    assign texel_xfer = in_xfer && (s_tuser == OP_TEXEL);

    assign b0    = s_tdata[15:8];
    assign addr0 = (image_format_reg == IMG_CLUT4) ? {4'h0, b0[3:0]}
                                                   : {b0[7:5], b0[3], b0[4], b0[2:0]};
    assign addr1 = {4'h0, b0[7:4]};

    ptd_palette_ram #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .clk      (clk),
        .wr_en    (in_xfer && (s_tuser == OP_WRITE)),
        .wr_addr  (s_tdata[7:0]),
        .wr_data  (s_tdata[39:8]),
        .rd_en    (texel_xfer),
        .rd_addr0 (addr0),
        .rd_addr1 (addr1),
        .rd_data0 (entry0),
        .rd_data1 (entry1)
    );

    ptd_texel_decode u_dec (
        .image_format   (image_format_reg),
        .palette_format (palette_format_reg),
        .data_word      (s1_data_reg),
        .entry0         (entry0),
        .entry1         (entry1),
        .second         (s1_second_reg),
        .result         (dec)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_second_next = s1_second_reg;
        if (texel_xfer)
        begin
            s1_valid_next  = 1'b1;
            s1_second_next = 1'b0;
        end
        else if (s1_done)
        begin
            s1_valid_next  = 1'b0;
            s1_second_next = 1'b0;
        end
        else if (s1_emit)
        begin
            s1_second_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_format_reg   <= IMG_A1BGR5;
            palette_format_reg <= PAL_ABGR8;
            s1_valid_reg       <= 1'b0;
            s1_second_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_FORMAT:   image_format_reg   <= cfg_data;
                    CFG_PALETTE_FORMAT: palette_format_reg <= cfg_data;
                    default:            ;
                endcase
            end
            s1_valid_reg  <= s1_valid_next;
            s1_second_reg <= s1_second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (texel_xfer)
        begin
            s1_data_reg <= s_tdata[39:8];
        end
        if (s1_emit)
        begin
            out_reg <= dec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.pixel;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

endmodule

>>> hdl/ptd_palette_ram.sv
// Palette memory: one write port, two registered read ports
module ptd_palette_ram #(
    parameter int PALETTE_DEPTH = ptd_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ptd_pkg::IDX_W-1:0]  wr_addr,
    input  logic [ptd_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ptd_pkg::IDX_W-1:0]  rd_addr0,
    input  logic [ptd_pkg::IDX_W-1:0]  rd_addr1,
    output logic [ptd_pkg::WORD_W-1:0] rd_data0,
    output logic [ptd_pkg::WORD_W-1:0] rd_data1
);
    import ptd_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [WORD_W-1:0] mem [PALETTE_DEPTH];
    logic [WORD_W-1:0] q0_reg;
    logic [WORD_W-1:0] q1_reg;
    logic              ok0_reg;
    logic              ok1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && (int'(wr_addr) < PALETTE_DEPTH))
        begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            q0_reg  <= mem[rd_addr0[AW-1:0]];
            q1_reg  <= mem[rd_addr1[AW-1:0]];
            ok0_reg <= int'(rd_addr0) < PALETTE_DEPTH;
            ok1_reg <= int'(rd_addr1) < PALETTE_DEPTH;
        end
    end

    // out-of-range indexes read as zero
    assign rd_data0 = ok0_reg ? q0_reg : '0;
    assign rd_data1 = ok1_reg ? q1_reg : '0;

endmodule

>>> hdl/ptd_texel_decode.sv
// Per-pixel decode of a registered texel by image and palette format
module ptd_texel_decode (
    input  logic [2:0]                 image_format,
    input  logic [2:0]                 palette_format,
    input  logic [ptd_pkg::WORD_W-1:0] data_word,
    input  logic [ptd_pkg::WORD_W-1:0] entry0,
    input  logic [ptd_pkg::WORD_W-1:0] entry1,
    input  logic                       second,
    output ptd_pkg::dec_out_t          result
);
    import ptd_pkg::*;

    logic [1:0]        pal_kind;
    logic              pal_ok;
    logic              two_pixels;
    logic [WORD_W-1:0] entry;

    always_comb
    begin
        pal_ok   = 1'b1;
        pal_kind = COLOR_ABGR8;
        unique case (palette_format)
            PAL_A1BGR5: pal_kind = COLOR_A1BGR5;
            PAL_XBGR8:  pal_kind = COLOR_XBGR8;
            PAL_ABGR8:  pal_kind = COLOR_ABGR8;
            default:    pal_ok   = 1'b0;
        endcase
    end

    assign entry = second ? entry1 : entry0;

    always_comb
    begin
        result.pixel  = '0;
        result.status = STATUS_OK;
        two_pixels    = 1'b0;
        unique case (image_format)
            IMG_A1BGR5: result.pixel = unpack_color({16'h0, data_word[15:0]}, COLOR_A1BGR5);
            IMG_XBGR8:  result.pixel = unpack_color(data_word, COLOR_XBGR8);
            IMG_ABGR8:  result.pixel = unpack_color(data_word, COLOR_ABGR8);
            IMG_CLUT4, IMG_CLUT8:
            begin
                if (pal_ok)
                begin
                    result.pixel = unpack_color(entry, pal_kind);
                    two_pixels   = (image_format == IMG_CLUT4);
                end
                else
                begin
                    result.status = STATUS_BAD_PALETTE;
                end
            end
            default:    result.status = STATUS_BAD_IMAGE;
        endcase
        result.last = !two_pixels || second;
    end

endmodule

>>> hdl/ptd_checker.sv
// Port-level checker for the palette texel decoder, bound to the top level
`include "palette_texel_decoder_top_defines.svh"

module ptd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import ptd_pkg::*;

    logic out_xfer;
    logic out_err;

    assign out_xfer = m_tvalid && m_tready;
    assign out_err  = m_tvalid && (m_tuser != STATUS_OK);

    `PTD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "stalled output dropped")
    `PTD_ASSERT_NOW(a_err_single, out_err, m_tlast && (m_tdata == '0), "error pixel not blank")
    `PTD_ASSERT_NOW(a_first_ok, m_tvalid && !m_tlast, m_tuser == STATUS_OK, "bad first pixel")
    `PTD_ASSERT_NEXT(a_second_follows, out_xfer && !m_tlast, m_tvalid, "second pixel missing")

endmodule

bind palette_texel_decoder_top ptd_checker u_ptd_checker (.*);
